// ===== rtl/mbrm_pkg.sv =====
package mbrm_pkg;

    localparam int REG_DEPTH = 128;
    localparam int COIL_COUNT = 8;
    localparam int ADDR_W = $clog2(REG_DEPTH);
    localparam int CNT_W = ADDR_W + 1;

    localparam logic [COIL_COUNT-1:0] COIL_RESET = COIL_COUNT'(8'h81);
    localparam logic [7:0] SLAVE_ID_RESET = 8'd1;
    localparam logic [7:0] EXC_FLAG = 8'h80;

    localparam logic [7:0] FN_READ_COILS = 8'd1;
    localparam logic [7:0] FN_READ_HOLDING = 8'd3;
    localparam logic [7:0] FN_READ_INPUT = 8'd4;
    localparam logic [7:0] FN_WRITE_COIL = 8'd5;
    localparam logic [7:0] FN_WRITE_REG = 8'd6;
    localparam logic [7:0] FN_WRITE_COILS = 8'd15;
    localparam logic [7:0] FN_WRITE_REGS = 8'd16;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_ILLEGAL_FN = 2'd1;
    localparam logic [1:0] ERR_ILLEGAL_ADDR = 2'd2;
    localparam logic [1:0] ERR_GATEWAY = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RD_ISSUE,
        ST_RD_EMIT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        OUT_EXC,
        OUT_COIL,
        OUT_ECHO_CNT,
        OUT_ECHO_VAL,
        OUT_READ
    } out_kind_t;

    typedef struct packed {
        logic      load_req;
        logic      load_out;
        out_kind_t kind;
        logic [1:0] err;
        logic      mem_wr;
        logic      wr_multi;
        logic      rd_start;
        logic      rd_issue;
    } dp_cmd_t;

    typedef struct packed {
        logic [7:0] fn;
        logic       unit_ok;
        logic       range_reg_ok;
        logic       range_coil_ok;
        logic       single_ok;
        logic       widx_ok;
        logic       lastw;
        logic       out_free;
        logic       rd_last;
    } dp_status_t;

endpackage

// ===== rtl/mbrm_ctrl.sv =====
module mbrm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mbrm_pkg::dp_status_t status,
    output mbrm_pkg::dp_cmd_t    cmd
);
    import mbrm_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        deferred;
    logic        multi_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign deferred = (status.fn == FN_WRITE_COILS) || (status.fn == FN_WRITE_REGS);
    assign multi_ok = status.range_reg_ok && status.widx_ok;

    always_comb begin
        state_next = state_reg;
        s_ready = 1'b0;
        cmd = '0;
        cmd.kind = OUT_EXC;
        cmd.err = ERR_NONE;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!status.unit_ok) begin
                    if (deferred && !status.lastw) begin
                        state_next = ST_IDLE;
                    end else if (status.out_free) begin
                        cmd.load_out = 1'b1;
                        cmd.err = ERR_GATEWAY;
                        state_next = ST_IDLE;
                    end
                end else begin
                    case (status.fn)
                        FN_READ_COILS: begin
                            if (status.out_free) begin
                                cmd.load_out = 1'b1;
                                if (status.range_coil_ok) begin
                                    cmd.kind = OUT_COIL;
                                end else begin
                                    cmd.err = ERR_ILLEGAL_ADDR;
                                end
                                state_next = ST_IDLE;
                            end
                        end
                        FN_READ_HOLDING, FN_READ_INPUT: begin
                            if (status.range_reg_ok) begin
                                cmd.rd_start = 1'b1;
                                state_next = ST_RD_ISSUE;
                            end else if (status.out_free) begin
                                cmd.load_out = 1'b1;
                                cmd.err = ERR_ILLEGAL_ADDR;
                                state_next = ST_IDLE;
                            end
                        end
                        FN_WRITE_COIL: begin
                            if (status.out_free) begin
                                cmd.load_out = 1'b1;
                                cmd.kind = OUT_ECHO_CNT;
                                state_next = ST_IDLE;
                            end
                        end
                        FN_WRITE_REG: begin
                            if (status.out_free) begin
                                cmd.load_out = 1'b1;
                                if (status.single_ok) begin
                                    cmd.mem_wr = 1'b1;
                                    cmd.kind = OUT_ECHO_VAL;
                                end else begin
                                    cmd.err = ERR_ILLEGAL_ADDR;
                                end
                                state_next = ST_IDLE;
                            end
                        end
                        FN_WRITE_COILS: begin
                            if (!status.lastw) begin
                                state_next = ST_IDLE;
                            end else if (status.out_free) begin
                                cmd.load_out = 1'b1;
                                cmd.err = ERR_ILLEGAL_FN;
                                state_next = ST_IDLE;
                            end
                        end
                        FN_WRITE_REGS: begin
                            cmd.wr_multi = 1'b1;
                            if (!status.lastw) begin
                                cmd.mem_wr = multi_ok;
                                state_next = ST_IDLE;
                            end else if (status.out_free) begin
                                cmd.mem_wr = multi_ok;
                                cmd.load_out = 1'b1;
                                if (status.range_reg_ok) begin
                                    cmd.kind = OUT_ECHO_CNT;
                                end else begin
                                    cmd.err = ERR_ILLEGAL_ADDR;
                                end
                                state_next = ST_IDLE;
                            end
                        end
                        default: begin
                            if (status.out_free) begin
                                cmd.load_out = 1'b1;
                                cmd.err = ERR_ILLEGAL_FN;
                                state_next = ST_IDLE;
                            end
                        end
                    endcase
                end
            end
            ST_RD_ISSUE: begin
                cmd.rd_issue = 1'b1;
                state_next = ST_RD_EMIT;
            end
            ST_RD_EMIT: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.kind = OUT_READ;
                    state_next = status.rd_last ? ST_IDLE : ST_RD_ISSUE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/mbrm_dp.sv =====
module mbrm_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [7:0]           slave_id,
    input  mbrm_pkg::dp_cmd_t    cmd,
    output mbrm_pkg::dp_status_t status,
    input  logic [7:0]           s_req_type,
    input  logic [15:0]          s_txn_id,
    input  logic [7:0]           s_unit_id,
    input  logic [15:0]          s_first_addr,
    input  logic [15:0]          s_quantity,
    input  logic [15:0]          s_write_value,
    input  logic [6:0]           s_word_index,
    input  logic                 s_last_word,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [15:0]          m_txn_id_out,
    output logic [7:0]           m_unit_out,
    output logic [7:0]           m_function_out,
    output logic [1:0]           m_error_code,
    output logic [7:0]           m_payload_bytes,
    output logic [15:0]          m_addr_echo,
    output logic [15:0]          m_count_echo,
    output logic [15:0]          m_data_first,
    output logic [15:0]          m_data_second,
    output logic [1:0]           m_words_valid,
    output logic                 m_last
);
    import mbrm_pkg::*;

    logic [7:0]  fn_reg;
    logic [15:0] tid_reg;
    logic [7:0]  unit_reg;
    logic [15:0] start_reg;
    logic [15:0] cnt_reg;
    logic [15:0] val_reg;
    logic [6:0]  widx_reg;
    logic        lastw_reg;

    logic [15:0]          mem [REG_DEPTH];
    logic [REG_DEPTH-1:0] valid_reg;
    logic [ADDR_W-1:0]    wr_addr;
    logic [ADDR_W-1:0]    ptr_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic                 is_input_reg;
    logic [15:0]          rd_a_reg;
    logic [15:0]          rd_b_reg;
    logic                 rva_reg;
    logic                 rvb_reg;

    logic [16:0] end_addr;
    logic [15:0] coil_word;
    logic [15:0] coil_mask;
    logic [7:0]  bc_sat;
    logic        two_words;
    logic [15:0] word_a;
    logic [15:0] word_b;

    logic        out_valid_reg;
    logic [7:0]  fn_out_reg;
    logic [1:0]  err_out_reg;
    logic [7:0]  bc_out_reg;
    logic [15:0] addr_out_reg;
    logic [15:0] count_out_reg;
    logic [15:0] d1_out_reg;
    logic [15:0] d2_out_reg;
    logic [1:0]  wv_out_reg;
    logic        last_out_reg;
    logic [15:0] tid_out_reg;
    logic [7:0]  unit_out_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            fn_reg <= s_req_type;
            tid_reg <= s_txn_id;
            unit_reg <= s_unit_id;
            start_reg <= s_first_addr;
            cnt_reg <= s_quantity;
            val_reg <= s_write_value;
            widx_reg <= s_word_index;
            lastw_reg <= s_last_word;
        end
    end

    assign end_addr = {1'b0, start_reg} + {1'b0, cnt_reg};

    assign status.fn = fn_reg;
    assign status.unit_ok = (unit_reg == slave_id);
    assign status.range_reg_ok = (cnt_reg != 16'd0) && (end_addr <= 17'(REG_DEPTH));
    assign status.range_coil_ok = (cnt_reg != 16'd0) && (end_addr <= 17'(COIL_COUNT));
    assign status.single_ok = (start_reg < 16'(REG_DEPTH));
    assign status.widx_ok = ({9'd0, widx_reg} < cnt_reg);
    assign status.lastw = lastw_reg;
    assign status.out_free = !out_valid_reg || m_ready;
    assign status.rd_last = (rem_reg <= CNT_W'(2));

    assign wr_addr = cmd.wr_multi ? (start_reg[ADDR_W-1:0] + widx_reg[ADDR_W-1:0])
                                  : start_reg[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            mem[wr_addr] <= val_reg;
        end
        if (cmd.rd_issue) begin
            rd_a_reg <= mem[ptr_reg];
            rd_b_reg <= mem[ptr_reg + ADDR_W'(1)];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.mem_wr) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_issue) begin
            rva_reg <= valid_reg[ptr_reg];
            rvb_reg <= valid_reg[ptr_reg + ADDR_W'(1)];
        end
        if (cmd.rd_start) begin
            ptr_reg <= start_reg[ADDR_W-1:0];
            rem_reg <= cnt_reg[CNT_W-1:0];
            is_input_reg <= (fn_reg == FN_READ_INPUT);
        end else if (cmd.load_out && cmd.kind == OUT_READ) begin
            ptr_reg <= ptr_reg + ADDR_W'(2);
            rem_reg <= rem_reg - CNT_W'(2);
        end
    end

    // The input register store is never written, so it always reads as zero.
    assign two_words = (rem_reg > CNT_W'(1));
    assign word_a = (is_input_reg || !rva_reg) ? 16'd0 : rd_a_reg;
    assign word_b = (is_input_reg || !rvb_reg || !two_words) ? 16'd0 : rd_b_reg;
    assign bc_sat = (cnt_reg > 16'd127) ? 8'hFF : {cnt_reg[6:0], 1'b0};
    assign coil_word = 16'(COIL_RESET) >> start_reg[3:0];
    assign coil_mask = (16'd1 << cnt_reg[3:0]) - 16'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            tid_out_reg <= tid_reg;
            unit_out_reg <= unit_reg;
            fn_out_reg <= fn_reg;
            err_out_reg <= ERR_NONE;
            bc_out_reg <= 8'd0;
            addr_out_reg <= 16'd0;
            count_out_reg <= 16'd0;
            d1_out_reg <= 16'd0;
            d2_out_reg <= 16'd0;
            wv_out_reg <= 2'd0;
            last_out_reg <= 1'b1;
            case (cmd.kind)
                OUT_EXC: begin
                    fn_out_reg <= fn_reg | EXC_FLAG;
                    err_out_reg <= cmd.err;
                end
                OUT_COIL: begin
                    bc_out_reg <= 8'd1;
                    d1_out_reg <= coil_word & coil_mask;
                    wv_out_reg <= 2'd1;
                end
                OUT_ECHO_CNT: begin
                    addr_out_reg <= start_reg;
                    count_out_reg <= cnt_reg;
                end
                OUT_ECHO_VAL: begin
                    addr_out_reg <= start_reg;
                    count_out_reg <= val_reg;
                end
                OUT_READ: begin
                    bc_out_reg <= bc_sat;
                    d1_out_reg <= word_a;
                    d2_out_reg <= word_b;
                    wv_out_reg <= two_words ? 2'd2 : 2'd1;
                    last_out_reg <= status.rd_last;
                end
                default: begin
                    fn_out_reg <= fn_reg | EXC_FLAG;
                    err_out_reg <= cmd.err;
                end
            endcase
        end
    end

    assign m_valid = out_valid_reg;
    assign m_txn_id_out = tid_out_reg;
    assign m_unit_out = unit_out_reg;
    assign m_function_out = fn_out_reg;
    assign m_error_code = err_out_reg;
    assign m_payload_bytes = bc_out_reg;
    assign m_addr_echo = addr_out_reg;
    assign m_count_echo = count_out_reg;
    assign m_data_first = d1_out_reg;
    assign m_data_second = d2_out_reg;
    assign m_words_valid = wv_out_reg;
    assign m_last = last_out_reg;

endmodule

// ===== rtl/modbus_register_map_server.sv =====
// Serves parsed Modbus requests (one item each, or one per word of a multiple
// write) against a 128-word holding register store, a read-only input
// register store and eight coils, with the server's unit id in the register
// at byte address 0. An item is taken in IDLE and decoded in DECODE in the
// next cycle; decoding waits while a reply is due and the output register is
// full. A register read builds each two-word result in RD_ISSUE and RD_EMIT,
// one registered access of both read ports each. Results are held in an
// output register, so the next request is taken while the last reply waits.
module modbus_register_map_server (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_req_type,
    input  logic [15:0] s_txn_id,
    input  logic [7:0]  s_unit_id,
    input  logic [15:0] s_first_addr,
    input  logic [15:0] s_quantity,
    input  logic [15:0] s_write_value,
    input  logic [6:0]  s_word_index,
    input  logic        s_last_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_txn_id_out,
    output logic [7:0]  m_unit_out,
    output logic [7:0]  m_function_out,
    output logic [1:0]  m_error_code,
    output logic [7:0]  m_payload_bytes,
    output logic [15:0] m_addr_echo,
    output logic [15:0] m_count_echo,
    output logic [15:0] m_data_first,
    output logic [15:0] m_data_second,
    output logic [1:0]  m_words_valid,
    output logic        m_last
);
    import mbrm_pkg::*;

    logic [7:0] slave_id_reg;
    dp_cmd_t    cmd;
    dp_status_t status;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {24'd0, slave_id_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_id_reg <= SLAVE_ID_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            slave_id_reg <= pwdata[7:0];
        end
    end

    mbrm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mbrm_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .slave_id        (slave_id_reg),
        .cmd             (cmd),
        .status          (status),
        .s_req_type      (s_req_type),
        .s_txn_id        (s_txn_id),
        .s_unit_id       (s_unit_id),
        .s_first_addr    (s_first_addr),
        .s_quantity      (s_quantity),
        .s_write_value   (s_write_value),
        .s_word_index    (s_word_index),
        .s_last_word     (s_last_word),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_txn_id_out    (m_txn_id_out),
        .m_unit_out      (m_unit_out),
        .m_function_out  (m_function_out),
        .m_error_code    (m_error_code),
        .m_payload_bytes (m_payload_bytes),
        .m_addr_echo     (m_addr_echo),
        .m_count_echo    (m_count_echo),
        .m_data_first    (m_data_first),
        .m_data_second   (m_data_second),
        .m_words_valid   (m_words_valid),
        .m_last          (m_last)
    );

endmodule
